// ----- hw/rtl/clp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types, constants and a helper function of the coordinate line parser.
// ----------------------------------------------------------------------------
package clp_pkg;

    localparam int LINE_CAP       = 64;
    localparam int COORD_BITS     = 16;
    localparam int COORD_FIELD_W  = 16;
    localparam int CNT_W          = $clog2(LINE_CAP);
    localparam int MAG_W          = COORD_BITS;
    localparam int PROD_W         = COORD_BITS + 4;
    localparam int KW_LEN         = 8;
    localparam int KW_IDX_W       = $clog2(KW_LEN);

    localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] MAG_MAX_POS = MAG_LIMIT - MAG_W'(1);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // "Sweeping"
    localparam logic [7:0] KEYWORD [KW_LEN] = '{
        8'h53, 8'h77, 8'h65, 8'h65, 8'h70, 8'h69, 8'h6E, 8'h67
    };

    typedef enum logic [1:0] {
        KIND_RX_BYTE      = 2'd0,
        KIND_FETCH_COORDS = 2'd1,
        KIND_FETCH_LOST   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } num_phase_t;

    typedef struct packed {
        num_phase_t       phase;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } num_state_t;

    // Line end report from the framer to the flag and coordinate logic.
    typedef struct packed {
        logic       fire;
        logic       keyword;
        logic       comma;
        num_state_t first;
        num_state_t second;
    } line_end_t;

    // Turn a saturated magnitude and sign into a signed coordinate.
    function automatic logic signed [COORD_BITS-1:0] num_value(input num_state_t n);
        logic [MAG_W-1:0] m;
        begin
            if (n.neg) begin
                m = ~n.mag + MAG_W'(1);
            end else if (n.mag > MAG_MAX_POS) begin
                m = MAG_MAX_POS;
            end else begin
                m = n.mag;
            end
            return $signed(m);
        end
    endfunction

endpackage

// ----- hw/rtl/coordinate_line_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_line_parser_core
// Frames received characters into lines, parses "x,y" coordinates and the
// target lost keyword, and answers coordinate and lost-flag fetch requests.
// ----------------------------------------------------------------------------
// Flow: an accepted request waits in the input register and is processed from
//   there; a fetch result is then registered and presented on m_.
// Throughput: one request per cycle, limited only by m_tready on fetches.
// Reset: synchronous on aresetn low; clears the line state, held coordinates,
//   both flags and the valid bits of the input and result registers.
// ----------------------------------------------------------------------------
module coordinate_line_parser_core
    import clp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] coord_x, [31:16] coord_y
    output logic [1:0]  m_tuser     // [0] coords_ready, [1] lost_seen
);

    // Input register: hold one request until it can be processed.
    logic                          in_valid_reg, in_valid_next;
    kind_t                         in_kind_reg;
    logic [7:0]                    in_byte_reg;

    // Held results and sticky flags.
    logic signed [COORD_BITS-1:0]  held_x_reg,   held_x_next;
    logic signed [COORD_BITS-1:0]  held_y_reg,   held_y_next;
    logic                          new_reg,      new_next;
    logic                          lost_reg,     lost_next;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    logic                          out_ready_reg, out_ready_next;
    logic                          out_lost_reg,  out_lost_next;
    logic [COORD_FIELD_W-1:0]      out_x_reg,     out_x_next;
    logic [COORD_FIELD_W-1:0]      out_y_reg,     out_y_next;

    logic      is_fetch_coords;
    logic      is_fetch_lost;
    logic      is_fetch;
    logic      out_free;
    logic      advance;
    logic      byte_strobe;
    line_end_t line_end;
    logic      coords_end;

    assign is_fetch_coords = (in_kind_reg == KIND_FETCH_COORDS);
    assign is_fetch_lost   = (in_kind_reg == KIND_FETCH_LOST);
    assign is_fetch        = is_fetch_coords || is_fetch_lost;

    // The result register frees up this cycle if it is empty or being taken.
    assign out_free = !out_valid_reg || m_tready;

    // Process the held request unless it is a fetch blocked by a full output.
    assign advance     = in_valid_reg && (!is_fetch || out_free);
    assign byte_strobe = advance && (in_kind_reg == KIND_RX_BYTE);
    assign s_tready    = !in_valid_reg || advance;

    clp_line u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_strobe (byte_strobe),
        .char_in     (in_byte_reg),
        .line_end    (line_end)
    );

    // A keyword line wins over a comma line.
    assign coords_end = line_end.fire && !line_end.keyword && line_end.comma;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        new_next    = new_reg;
        lost_next   = lost_reg;
        if (line_end.fire && line_end.keyword) begin
            lost_next = 1'b1;
        end else if (coords_end) begin
            held_x_next = num_value(line_end.first);
            held_y_next = num_value(line_end.second);
            new_next    = 1'b1;
            lost_next   = 1'b0;
        end
        // Fetches read and clear their flag.
        if (advance && is_fetch_coords) begin
            new_next = 1'b0;
        end
        if (advance && is_fetch_lost) begin
            lost_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_ready_next = out_ready_reg;
        out_lost_next  = out_lost_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        if (advance && is_fetch) begin
            out_valid_next = 1'b1;
            out_ready_next = is_fetch_coords && new_reg;
            out_lost_next  = is_fetch_lost && lost_reg;
            out_x_next     = (is_fetch_coords && new_reg) ?
                             COORD_FIELD_W'(held_x_reg) : '0;
            out_y_next     = (is_fetch_coords && new_reg) ?
                             COORD_FIELD_W'(held_y_reg) : '0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            new_reg       <= 1'b0;
            lost_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            new_reg       <= new_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= kind_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
        out_ready_reg <= out_ready_next;
        out_lost_reg  <= out_lost_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = {out_lost_reg, out_ready_reg};

    // A result never reports both flags at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result carries both coords_ready and lost_seen");

    // Coordinates are zero unless new coordinates are reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("coordinates nonzero without coords_ready");

    // A processed coordinate fetch clears the pending flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_fetch_coords) |=> !new_reg)
        else $error("new-coordinates flag survived a fetch");

    // A processed lost fetch clears the lost flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_fetch_lost) |=> !lost_reg)
        else $error("lost flag survived a fetch");

    // A coordinate line sets new data and clears the lost flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        coords_end |=> (new_reg && !lost_reg))
        else $error("coordinate line did not update flags");

endmodule

// ----- hw/rtl/clp_number.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_number
// Next-state logic of one integer field: skip whitespace, take one sign,
// accumulate decimal digits with saturation, stop at the first non-digit.
// ----------------------------------------------------------------------------
module clp_number
    import clp_pkg::*;
(
    input  num_state_t  cur,
    input  logic [7:0]  char_in,
    output num_state_t  nxt
);

    logic              is_digit;
    logic              is_space;
    logic [PROD_W-1:0] acc;
    logic [MAG_W-1:0]  acc_sat;

    assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign is_space = (char_in == CHAR_SPACE) ||
                      ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));

    // mag * 10 + digit, as two shifts and two adds
    assign acc = (PROD_W'(cur.mag) << 3) + (PROD_W'(cur.mag) << 1)
               + PROD_W'(char_in[3:0]);
    assign acc_sat = (acc > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : acc[MAG_W-1:0];

    always_comb begin
        nxt = cur;
        unique case (cur.phase)
            PH_SKIP: begin
                if (is_space) begin
                    nxt = cur;
                end else if ((char_in == CHAR_PLUS) || (char_in == CHAR_MINUS)) begin
                    nxt.neg   = (char_in == CHAR_MINUS);
                    nxt.phase = PH_DIGITS;
                end else if (is_digit) begin
                    nxt.phase = PH_DIGITS;
                    nxt.mag   = acc_sat;
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    nxt.mag = acc_sat;
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
            PH_DONE: begin
                nxt = cur;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- hw/rtl/clp_line.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_line
// Line framer: counts characters, tracks the keyword match and the first
// comma, runs both number fields, and reports each non-empty line end.
// ----------------------------------------------------------------------------
module clp_line
    import clp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_strobe,
    input  logic [7:0]  char_in,
    output line_end_t   line_end
);

    logic [CNT_W-1:0]    count_reg,   count_next;
    logic                zero_reg,    zero_next;
    logic [KW_IDX_W-1:0] match_reg,   match_next;
    logic                keyword_reg, keyword_next;
    logic                comma_reg,   comma_next;
    num_state_t          first_reg,   first_next;
    num_state_t          second_reg,  second_next;

    num_state_t          first_fed;
    num_state_t          second_fed;
    logic                is_eol;

    clp_number u_first (
        .cur     (first_reg),
        .char_in (char_in),
        .nxt     (first_fed)
    );

    clp_number u_second (
        .cur     (second_reg),
        .char_in (char_in),
        .nxt     (second_fed)
    );

    assign is_eol = (char_in == CHAR_LF) || (char_in == CHAR_CR);

    assign line_end.fire    = byte_strobe && is_eol && (count_reg != '0);
    assign line_end.keyword = keyword_reg;
    assign line_end.comma   = comma_reg;
    assign line_end.first   = first_reg;
    assign line_end.second  = second_reg;

    always_comb begin
        count_next   = count_reg;
        zero_next    = zero_reg;
        match_next   = match_reg;
        keyword_next = keyword_reg;
        comma_next   = comma_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        if (byte_strobe) begin
            if (is_eol) begin
                if (count_reg != '0) begin
                    count_next   = '0;
                    zero_next    = 1'b0;
                    match_next   = '0;
                    keyword_next = 1'b0;
                    comma_next   = 1'b0;
                    first_next   = '0;
                    second_next  = '0;
                end
            end else if (count_reg < CNT_W'(LINE_CAP - 1)) begin
                count_next = count_reg + CNT_W'(1);
                if (char_in == CHAR_NUL) begin
                    zero_next = 1'b1;
                end else if (!zero_reg) begin
                    if (!keyword_reg) begin
                        if (char_in == KEYWORD[match_reg]) begin
                            if (match_reg == KW_IDX_W'(KW_LEN - 1)) begin
                                keyword_next = 1'b1;
                                match_next   = '0;
                            end else begin
                                match_next = match_reg + KW_IDX_W'(1);
                            end
                        end else begin
                            match_next = (char_in == KEYWORD[0]) ? KW_IDX_W'(1) : '0;
                        end
                    end
                    if (!comma_reg && (char_in == CHAR_COMMA)) begin
                        comma_next = 1'b1;
                    end else if (!comma_reg) begin
                        first_next = first_fed;
                    end else begin
                        second_next = second_fed;
                    end
                end
            end else begin
                // overlong line: drop it along with this byte
                count_next   = '0;
                zero_next    = 1'b0;
                match_next   = '0;
                keyword_next = 1'b0;
                comma_next   = 1'b0;
                first_next   = '0;
                second_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            zero_reg    <= 1'b0;
            match_reg   <= '0;
            keyword_reg <= 1'b0;
            comma_reg   <= 1'b0;
            first_reg   <= '0;
            second_reg  <= '0;
        end else begin
            count_reg   <= count_next;
            zero_reg    <= zero_next;
            match_reg   <= match_next;
            keyword_reg <= keyword_next;
            comma_reg   <= comma_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
        end
    end

endmodule
